FILE: hdl/mucd_pkg.sv
// Package: shared types, constants and the control-store contents of the cycle decomposer.
package mucd_pkg;

   localparam int VERTICES_DEFAULT = 16;
   localparam int NIBBLE_W         = 4;
   localparam int WORD_W           = 64;
   localparam int STEP_W           = 3;

   // Input item.
   typedef struct packed {
      logic [WORD_W-1:0] matching_first;
      logic [WORD_W-1:0] matching_second;
   } req_type;

   // Result item.
   typedef struct packed {
      logic [3:0] vertex;
      logic [2:0] cycle_index;
      logic [3:0] position;
      logic       cycle_end;
      logic [4:0] cycle_length;
      logic       malformed;
      logic       last;
   } rsp_type;

   // Microcode operations.
   typedef enum logic [1:0] {
      OP_IDLE,
      OP_INIT,
      OP_WALK,
      OP_ERROR
   } op_type;

   typedef logic [STEP_W-1:0] step_type;

   // Program addresses.
   localparam step_type STEP_IDLE       = 3'd0;
   localparam step_type STEP_INIT_CHECK = 3'd1;
   localparam step_type STEP_WALK_CHECK = 3'd2;
   localparam step_type STEP_INIT_EMIT  = 3'd3;
   localparam step_type STEP_WALK_EMIT  = 3'd4;
   localparam step_type STEP_ERROR      = 3'd5;

   // One control word per step.
   typedef struct packed {
      op_type   op;
      logic     emit;
      step_type next_step;
      step_type fail_step;
   } ctrl_type;

   // Conditions reported by the datapath to the sequencer.
   typedef struct packed {
      logic start;
      logic bad;
      logic done;
   } cond_type;

   function automatic ctrl_type rom_word(input step_type step);
      ctrl_type word;
      word = '{op: OP_IDLE, emit: 1'b0, next_step: STEP_INIT_CHECK, fail_step: STEP_IDLE};
      unique case (step)
         STEP_IDLE: begin
            word = '{op: OP_IDLE, emit: 1'b0, next_step: STEP_INIT_CHECK,
                     fail_step: STEP_IDLE};
         end
         STEP_INIT_CHECK: begin
            word = '{op: OP_INIT, emit: 1'b0, next_step: STEP_WALK_CHECK,
                     fail_step: STEP_IDLE};
         end
         STEP_WALK_CHECK: begin
            word = '{op: OP_WALK, emit: 1'b0, next_step: STEP_INIT_EMIT,
                     fail_step: STEP_ERROR};
         end
         STEP_INIT_EMIT: begin
            word = '{op: OP_INIT, emit: 1'b1, next_step: STEP_WALK_EMIT,
                     fail_step: STEP_IDLE};
         end
         STEP_WALK_EMIT: begin
            word = '{op: OP_WALK, emit: 1'b1, next_step: STEP_IDLE,
                     fail_step: STEP_ERROR};
         end
         STEP_ERROR: begin
            word = '{op: OP_ERROR, emit: 1'b1, next_step: STEP_IDLE,
                     fail_step: STEP_IDLE};
         end
         default: begin
            word = '{op: OP_IDLE, emit: 1'b0, next_step: STEP_IDLE, fail_step: STEP_IDLE};
         end
      endcase
      return word;
   endfunction

endpackage

FILE: hdl/mucd_sequencer.sv
// Microcode sequencer: step counter, control store and conditional jumps.
module mucd_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  mucd_pkg::cond_type cond,
   output mucd_pkg::ctrl_type ctrl,
   output logic               busy
);

   mucd_pkg::step_type step_ff;
   mucd_pkg::step_type step_in;

   assign ctrl = mucd_pkg::rom_word(step_ff);
   assign busy = (ctrl.op != mucd_pkg::OP_IDLE);

   always_comb begin
      step_in = step_ff;
      unique case (ctrl.op)
         mucd_pkg::OP_IDLE: begin
            if (cond.start) begin
               step_in = ctrl.next_step;
            end
         end
         mucd_pkg::OP_INIT, mucd_pkg::OP_ERROR: begin
            step_in = ctrl.next_step;
         end
         mucd_pkg::OP_WALK: begin
            if (cond.bad) begin
               step_in = ctrl.fail_step;
            end else if (cond.done) begin
               step_in = ctrl.next_step;
            end
         end
         default: begin
            step_in = mucd_pkg::STEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= mucd_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

FILE: hdl/matching_union_cycle_decompose.sv
// Top level: alternating cycle decomposition of the union of two perfect matchings.
//
// Pulse start while busy is low to hand over one item: two matchings, nibble i of
// each word holding the partner of vertex i. The block splits their union into
// alternating cycles, starting each cycle at the lowest vertex not yet visited and
// stepping through the first matching, then the second. It produces one result per
// visited vertex, each on rsp_data for exactly one cycle with rsp_valid high; the
// receiver must take every result as it comes. The closing vertex of a cycle carries
// cycle_end and the length, the final result carries last. A walk that would visit
// more than VERTICES vertices, or a partner at or above VERTICES, yields a single
// result with malformed and last set and nothing else. The walk runs twice: a check
// pass, then an emit pass, each one vertex per clock through one shared walk unit
// driven by a small microcode program. A well-formed item keeps busy high through
// both passes and its VERTICES results appear on consecutive cycles. A new item
// may be started in the cycle after busy falls.
module matching_union_cycle_decompose #(
   parameter int VERTICES = mucd_pkg::VERTICES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mucd_pkg::req_type req_data,
   output logic              rsp_valid,
   output mucd_pkg::rsp_type rsp_data
);

   localparam int NW = mucd_pkg::NIBBLE_W;

   mucd_pkg::ctrl_type ctrl;
   mucd_pkg::cond_type cond;

   // Captured item.
   mucd_pkg::req_type req_ff;

   // Walk state.
   logic [NW-1:0]       cur_ff, cur_in;
   logic [NW-1:0]       origin_ff, origin_in;
   logic [NW-1:0]       pos_ff, pos_in;
   logic [2:0]          cyc_ff, cyc_in;
   logic [4:0]          total_ff, total_in;
   logic                half_ff, half_in;
   logic [VERTICES-1:0] seen_ff, seen_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   mucd_pkg::rsp_type   rsp_ff, rsp_in;

   // Walk unit.
   logic [NW-1:0]       partner;
   logic [VERTICES-1:0] cur_mask;
   logic [VERTICES-1:0] seen_next;
   logic [NW-1:0]       lowest_unseen;
   logic                bad;
   logic                closing;
   logic                all_seen;
   logic                done;

   mucd_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   assign cond = '{start: start, bad: bad, done: done};

   // Follow the first matching on the first half-step, the second on the other.
   always_comb begin
      if (half_ff) begin
         partner = req_ff.matching_second[{cur_ff, 2'b00} +: NW];
      end else begin
         partner = req_ff.matching_first[{cur_ff, 2'b00} +: NW];
      end
   end

   // Flag a partner beyond the vertex range or a walk past the vertex count.
   assign bad = ({1'b0, cur_ff} >= 5'(VERTICES)) || (total_ff >= 5'(VERTICES));

   always_comb begin
      for (int i = 0; i < VERTICES; i++) begin
         cur_mask[i] = (cur_ff == NW'(i));
      end
   end

   assign seen_next = seen_ff | cur_mask;
   assign all_seen  = &seen_next;
   assign closing   = half_ff && (partner == origin_ff);
   assign done      = closing && all_seen;

   // Pick the next cycle start: every vertex below the current start is seen, so
   // the lowest unseen vertex is the next one the scan would reach.
   always_comb begin
      lowest_unseen = '0;
      for (int i = VERTICES - 1; i >= 0; i--) begin
         if (!seen_next[i]) begin
            lowest_unseen = NW'(i);
         end
      end
   end

   // Walk datapath driven by the control word.
   always_comb begin
      cur_in    = cur_ff;
      origin_in = origin_ff;
      pos_in    = pos_ff;
      cyc_in    = cyc_ff;
      total_in  = total_ff;
      half_in   = half_ff;
      seen_in   = seen_ff;
      case (ctrl.op)
         mucd_pkg::OP_INIT: begin
            cur_in    = '0;
            origin_in = '0;
            pos_in    = '0;
            cyc_in    = '0;
            total_in  = '0;
            half_in   = 1'b0;
            seen_in   = '0;
         end
         mucd_pkg::OP_WALK: begin
            if (!bad) begin
               seen_in  = seen_next;
               total_in = total_ff + 5'd1;
               if (closing) begin
                  // Close this cycle and open the next at the lowest unseen vertex.
                  cur_in    = lowest_unseen;
                  origin_in = lowest_unseen;
                  pos_in    = '0;
                  cyc_in    = cyc_ff + 3'd1;
                  half_in   = 1'b0;
               end else begin
                  cur_in  = partner;
                  pos_in  = pos_ff + NW'(1);
                  half_in = ~half_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Build the result: one per vertex in the emit pass, a lone error on a malformed item.
   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      case (ctrl.op)
         mucd_pkg::OP_WALK: begin
            if (ctrl.emit && !bad) begin
               rsp_valid_in        = 1'b1;
               rsp_in.vertex       = cur_ff;
               rsp_in.cycle_index  = cyc_ff;
               rsp_in.position     = pos_ff;
               rsp_in.cycle_end    = closing;
               rsp_in.cycle_length = closing ? ({1'b0, pos_ff} + 5'd1) : 5'd0;
               rsp_in.last         = done;
            end
         end
         mucd_pkg::OP_ERROR: begin
            rsp_valid_in     = 1'b1;
            rsp_in.malformed = 1'b1;
            rsp_in.last      = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Hold the item for both passes.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      origin_ff <= origin_in;
      pos_ff    <= pos_in;
      cyc_ff    <= cyc_in;
      total_ff  <= total_in;
      half_ff   <= half_in;
      seen_ff   <= seen_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
